@@ src/mbas_pkg.sv @@
package mbas_pkg;

    localparam int FRAME_CHARS_DEF = 64;
    localparam int MIN_CHARS       = 9;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] FC_READ_INPUT = 8'h04;
    localparam logic [7:0] EXC_FLAG      = 8'h80;
    localparam logic [7:0] EXC_FUNC      = 8'h01;
    localparam logic [7:0] EXC_ADDR      = 8'h02;
    localparam logic [7:0] EXC_VALUE     = 8'h03;
    localparam logic [15:0] QTY_MAX      = 16'h007D;
    localparam logic [15:0] ERR_MAX      = 16'hFFFF;

    localparam logic [0:0] REG_SLAVE = 1'b0;
    localparam logic [0:0] REG_START = 1'b1;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_NO_CR    = 4'd2,
        ST_ODD      = 4'd3,
        ST_NON_HEX  = 4'd4,
        ST_LRC      = 4'd5,
        ST_STRAY    = 4'd6,
        ST_OVERFLOW = 4'd7,
        ST_RESTART  = 4'd8
    } status_t;

    // Command handed from front to back through the queue
    typedef struct packed {
        logic        check;     // LF closed a frame: run the checks
        status_t     status;    // status when no check is run
        logic [7:0]  size;      // char count including LF
        logic [15:0] sensor;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_READ,
        BK_HEX,
        BK_EVAL,
        BK_ERR,
        BK_STATUS,
        BK_SEND
    } bk_state_t;

    function automatic logic [4:0] hex_value(input logic [7:0] h);
        logic [4:0] r;
        begin
            r = 5'h10;
            if (h >= 8'h30 && h <= 8'h39)
                r = {1'b0, h[3:0]};
            else if (h >= 8'h41 && h <= 8'h46)
                r = {1'b0, h[3:0] + 4'd9};
            return r;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        begin
            if (n < 4'd10)
                r = 8'h30 + {4'd0, n};
            else
                r = 8'h37 + {4'd0, n};
            return r;
        end
    endfunction

endpackage

@@ src/modbus_ascii_slave_frame_handler.sv @@
// Modbus ASCII slave, function 4 on one input register. Each accepted
// character beat yields one status beat, or for an LF that closes a valid
// frame addressed here, 11 (exception) or 15 (answer) response character
// beats. The front stage takes a character per cycle, unless the queue is
// full, into the frame store and a two-entry command queue, and stalls input
// from a closing LF until the back stage has scanned that frame, as both
// share the store. Commands are registered in the queue. The back stage scans
// the stored frame one character a cycle from its single read port. A closing
// LF passes the idle, read, hex, eval, error and status or send states, a
// frame under nine characters idle, error and status, any other character
// idle and status, each result beat held by any output stall.
module modbus_ascii_slave_frame_handler #(
    parameter int FRAME_CHARS = mbas_pkg::FRAME_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_char,
    input  logic [15:0] sensor_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        char_valid,
    output logic [7:0]  tx_char,
    output logic        last,
    output logic [3:0]  frame_status,
    output logic [15:0] error_count
);
    import mbas_pkg::*;

    localparam int AW = $clog2(FRAME_CHARS);

    logic [7:0]  slave_reg;
    logic [15:0] start_reg;
    logic        push, full, q_valid, pop, wr_en, scan_done;
    cmd_t        push_cmd, head;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_reg <= 8'd1;
            start_reg <= 16'd1;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SLAVE)
                slave_reg <= cfg_data[7:0];
            else
                start_reg <= cfg_data;
        end
    end

    mbas_front #(.FRAME_CHARS(FRAME_CHARS), .AW(AW)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .rx_char, .sensor_value,
        .q_push(push), .q_cmd(push_cmd), .q_full(full), .scan_done,
        .wr_en, .wr_addr, .wr_data
    );

    mbas_queue u_queue (
        .clk, .rst_n, .push, .push_cmd, .full, .not_empty(q_valid),
        .pop, .head
    );

    mbas_back #(.FRAME_CHARS(FRAME_CHARS), .AW(AW)) u_back (
        .clk, .rst_n, .slave_address(slave_reg), .register_address(start_reg),
        .q_valid, .q_cmd(head), .q_pop(pop), .scan_done, .wr_en, .wr_addr, .wr_data,
        .out_valid, .out_stall, .char_valid, .tx_char, .last, .frame_status,
        .error_count
    );

`ifndef SYNTHESIS
    a_stat_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> frame_status == 4'd0)
        else $error("status on response char");
    a_err_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) && !$past(out_stall)
        |-> error_count >= $past(error_count))
        else $error("error count fell");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> last)
        else $error("status beat not last");
`endif

endmodule

@@ src/mbas_front.sv @@
module mbas_front #(
    parameter int FRAME_CHARS = mbas_pkg::FRAME_CHARS_DEF,
    parameter int AW = $clog2(FRAME_CHARS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_char,
    input  logic [15:0]         sensor_value,
    output logic                q_push,
    output mbas_pkg::cmd_t      q_cmd,
    input  logic                q_full,
    input  logic                scan_done,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data
);
    import mbas_pkg::*;

    localparam int CW = $clog2(FRAME_CHARS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          hold_reg;
    logic          take;

    // hold input while the queue is full or a closed frame still sits in the store unscanned
    assign in_stall = q_full || hold_reg;
    assign take     = in_valid && !in_stall;
    assign q_push   = take;

    always_comb
    begin
        count_next    = count_reg;
        q_cmd.check   = 1'b0;
        q_cmd.status  = ST_OK;
        q_cmd.size    = 8'(count_reg) + 8'd1;
        q_cmd.sensor  = sensor_value;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = rx_char;
        if (rx_char == CH_COLON) begin
            if (count_reg != '0)
                q_cmd.status = ST_RESTART;
            wr_en      = take;
            wr_addr    = '0;
            count_next = CW'(1);
        end else if (count_reg == '0) begin
            q_cmd.status = ST_STRAY;
        end else if (count_reg >= CW'(FRAME_CHARS)) begin
            q_cmd.status = ST_OVERFLOW;
        end else begin
            wr_en      = take;
            count_next = count_reg + CW'(1);
            if (rx_char == CH_LF) begin
                q_cmd.check = 1'b1;
                count_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (take)
            count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (scan_done)
            hold_reg <= 1'b0;
        else if (take && q_cmd.check)
            hold_reg <= 1'b1;
    end

endmodule

@@ src/mbas_queue.sv @@
module mbas_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mbas_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output mbas_pkg::cmd_t head
);
    import mbas_pkg::*;

    cmd_t       slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ src/mbas_back.sv @@
module mbas_back #(
    parameter int FRAME_CHARS = mbas_pkg::FRAME_CHARS_DEF,
    parameter int AW = $clog2(FRAME_CHARS)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      slave_address,
    input  logic [15:0]     register_address,
    input  logic            q_valid,
    input  mbas_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            scan_done,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [7:0]      wr_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            char_valid,
    output logic [7:0]      tx_char,
    output logic            last,
    output logic [3:0]      frame_status,
    output logic [15:0]     error_count
);
    import mbas_pkg::*;

    logic [7:0] mem [FRAME_CHARS];
    logic [7:0] rd_data_reg;

    bk_state_t state_reg, state_next;

    cmd_t       cmd_reg;
    logic [7:0] idx_reg;
    logic [3:0] hi_reg;
    logic       half_reg;
    logic       nonhex_reg;
    logic       cr_bad_reg;
    logic [7:0] sum_reg;
    logic [7:0] msg_reg [6];
    status_t    status_reg;
    logic [7:0] resp_reg [5];
    logic [2:0] nresp_reg;
    logic [3:0] ch_idx_reg;
    logic [15:0] err_reg;
    logic       o_valid_reg;
    logic       o_cv_reg, o_last_reg;
    logic [7:0] o_char_reg;
    logic [3:0] o_stat_reg;
    logic [15:0] o_err_reg;

    logic       o_free;
    logic [4:0] hv;
    logic [7:0] byte_val;
    logic [AW-1:0] rd_addr;
    logic [3:0] nchars;
    logic [7:0] lrc;
    logic [7:0] send_char;

    assign o_free = !o_valid_reg || !out_stall;
    assign hv     = hex_value(rd_data_reg);
    assign byte_val = {hi_reg, hv[3:0]};
    assign rd_addr  = idx_reg[AW-1:0];
    assign nchars   = (nresp_reg == 3'd5) ? 4'd14 : 4'd10;
    assign lrc      = 8'd0 - (resp_reg[0] + resp_reg[1] + resp_reg[2]
                              + resp_reg[3] + resp_reg[4]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        unique case (ch_idx_reg)
            4'd0:    send_char = CH_COLON;
            4'd1:    send_char = hex_digit(resp_reg[0][7:4]);
            4'd2:    send_char = hex_digit(resp_reg[0][3:0]);
            4'd3:    send_char = hex_digit(resp_reg[1][7:4]);
            4'd4:    send_char = hex_digit(resp_reg[1][3:0]);
            4'd5:    send_char = hex_digit(resp_reg[2][7:4]);
            4'd6:    send_char = hex_digit(resp_reg[2][3:0]);
            default: send_char = CH_LF;
        endcase
        if (ch_idx_reg >= 4'd7) begin
            if (ch_idx_reg == nchars)
                send_char = CH_LF;
            else if (ch_idx_reg == nchars - 4'd1)
                send_char = CH_CR;
            else if (ch_idx_reg == nchars - 4'd2)
                send_char = hex_digit(lrc[3:0]);
            else if (ch_idx_reg == nchars - 4'd3)
                send_char = hex_digit(lrc[7:4]);
            else if (ch_idx_reg == 4'd7)
                send_char = hex_digit(resp_reg[3][7:4]);
            else if (ch_idx_reg == 4'd8)
                send_char = hex_digit(resp_reg[3][3:0]);
            else if (ch_idx_reg == 4'd9)
                send_char = hex_digit(resp_reg[4][7:4]);
            else
                send_char = hex_digit(resp_reg[4][3:0]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (q_valid) begin
                    if (!q_cmd.check)
                        state_next = BK_STATUS;
                    else if (q_cmd.size < 8'(MIN_CHARS))
                        state_next = BK_ERR;
                    else
                        state_next = BK_READ;
                end
            BK_READ:
                state_next = BK_HEX;
            BK_HEX:
                if (idx_reg == cmd_reg.size - 8'd1)
                    state_next = BK_EVAL;
            BK_EVAL:
                state_next = BK_ERR;
            BK_ERR:
                state_next = (nresp_reg != 3'd0) ? BK_SEND : BK_STATUS;
            BK_STATUS:
                if (o_free)
                    state_next = BK_IDLE;
            BK_SEND:
                if (o_free && ch_idx_reg == nchars)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = (state_reg == BK_IDLE) && q_valid;
        scan_done = (state_reg == BK_ERR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= BK_IDLE;
            err_reg     <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (o_valid_reg && !out_stall)
                o_valid_reg <= 1'b0;
            unique case (state_reg)
                BK_IDLE:
                    if (q_valid && !q_cmd.check && q_cmd.status != ST_OK
                        && err_reg != ERR_MAX)
                        err_reg <= err_reg + 16'd1;
                BK_ERR:
                    if (status_reg != ST_OK && err_reg != ERR_MAX)
                        err_reg <= err_reg + 16'd1;
                BK_STATUS:
                    if (o_free)
                        o_valid_reg <= 1'b1;
                BK_SEND:
                    if (o_free)
                        o_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_reg     <= q_cmd;
                status_reg  <= (q_cmd.check && q_cmd.size < 8'(MIN_CHARS))
                               ? ST_SHORT : q_cmd.status;
                idx_reg     <= 8'd1;
                nonhex_reg  <= 1'b0;
                half_reg    <= 1'b0;
                sum_reg     <= '0;
                nresp_reg   <= '0;
                ch_idx_reg  <= '0;
                resp_reg[3] <= '0;
                resp_reg[4] <= '0;
            end
            BK_READ:
                idx_reg <= idx_reg + 8'd1;
            BK_HEX:
            begin
                // data of char idx-1 arrives now; hex chars are 1 .. size-3
                if (idx_reg <= cmd_reg.size - 8'd2) begin
                    if (hv[4])
                        nonhex_reg <= 1'b1;
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        sum_reg <= sum_reg + byte_val;
                        if (idx_reg < 8'd14)
                            msg_reg[3'((idx_reg - 8'd3) >> 1)] <= byte_val;
                    end else begin
                        hi_reg <= hv[3:0];
                    end
                end
                idx_reg <= idx_reg + 8'd1;
            end
            BK_EVAL:
            begin
                resp_reg[0] <= msg_reg[0];
                if (cr_bad_reg) begin
                    status_reg <= ST_NO_CR;
                end else if (cmd_reg.size[0] == 1'b0) begin
                    status_reg <= ST_ODD;
                end else if (nonhex_reg) begin
                    status_reg <= ST_NON_HEX;
                end else if (sum_reg != 8'd0) begin
                    status_reg <= ST_LRC;
                end else if (msg_reg[0] != slave_address) begin
                    status_reg <= ST_OK;
                end else if (msg_reg[1] == FC_READ_INPUT) begin
                    if (cmd_reg.size < 8'd17) begin
                        status_reg <= ST_SHORT;
                    end else if ({msg_reg[4], msg_reg[5]} == 16'd0
                                 || {msg_reg[4], msg_reg[5]} > QTY_MAX) begin
                        resp_reg[1] <= EXC_FLAG | msg_reg[1];
                        resp_reg[2] <= EXC_VALUE;
                        nresp_reg   <= 3'd3;
                    end else if ({msg_reg[2], msg_reg[3]} != register_address
                                 || {msg_reg[4], msg_reg[5]} != 16'd1) begin
                        resp_reg[1] <= EXC_FLAG | msg_reg[1];
                        resp_reg[2] <= EXC_ADDR;
                        nresp_reg   <= 3'd3;
                    end else begin
                        resp_reg[1] <= FC_READ_INPUT;
                        resp_reg[2] <= 8'd2;
                        resp_reg[3] <= cmd_reg.sensor[15:8];
                        resp_reg[4] <= cmd_reg.sensor[7:0];
                        nresp_reg   <= 3'd5;
                    end
                end else begin
                    resp_reg[1] <= EXC_FLAG | msg_reg[1];
                    resp_reg[2] <= EXC_FUNC;
                    nresp_reg   <= 3'd3;
                end
            end
            BK_SEND:
                if (o_free)
                    ch_idx_reg <= ch_idx_reg + 4'd1;
            default: ;
        endcase
        if (state_reg == BK_STATUS && o_free) begin
            o_cv_reg   <= 1'b0;
            o_char_reg <= '0;
            o_last_reg <= 1'b1;
            o_stat_reg <= status_reg;
            o_err_reg  <= err_reg;
        end else if (state_reg == BK_SEND && o_free) begin
            o_cv_reg   <= 1'b1;
            o_char_reg <= send_char;
            o_last_reg <= ch_idx_reg == nchars;
            o_stat_reg <= ST_OK;
            o_err_reg  <= err_reg;
        end
    end

    // CR check: char at size-2 arrives on the last scan cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE)
            cr_bad_reg <= 1'b1;
        else if (state_reg == BK_HEX && idx_reg == cmd_reg.size - 8'd1)
            cr_bad_reg <= rd_data_reg != CH_CR;
    end

    assign out_valid    = o_valid_reg;
    assign char_valid   = o_cv_reg;
    assign tx_char      = o_char_reg;
    assign last         = o_last_reg;
    assign frame_status = o_stat_reg;
    assign error_count  = o_err_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import mbas_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic        is_char;
        logic [7:0]  ch;
        logic        fin;
        logic [3:0]  st;
        logic [15:0] errs;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_SLAVE;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_char = 8'd0;
    logic [15:0] sensor_value = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        char_valid;
    logic [7:0]  tx_char;
    logic        last;
    logic [3:0]  frame_status;
    logic [15:0] error_count;

    // shadow of the slave
    logic [7:0]  my_slave = 8'd1;
    logic [15:0] my_register = 16'd1;
    logic [7:0]  frame_buf[64];
    int          buffered = 0;
    logic [15:0] errors_seen = 16'd0;
    logic [7:0]  answer[5];
    int          answer_len;

    beat_t       pending_beats[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          random_chars = 0;

    modbus_ascii_slave_frame_handler dut (.*);

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [7:0] to_hex(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h41 + {4'd0, n} - 8'd10;
    endfunction

    function automatic int nibble_of(input logic [7:0] h);
        if (h >= "0" && h <= "9")
            return h - "0";
        if (h >= "A" && h <= "F")
            return h - "A" + 10;
        return -1;
    endfunction

    function automatic void count_error();
        if (errors_seen != 16'hFFFF)
            errors_seen = errors_seen + 16'd1;
    endfunction

    function automatic status_t judge_frame(input logic [15:0] sensor);
        logic [7:0]  msg[33];
        logic [7:0]  fc;
        logic [15:0] start_reg;
        logic [15:0] qty;
        int          size;
        int          n;
        int          sum;
        size = buffered;
        sum = 0;
        answer_len = 0;
        if (size < MIN_CHARS || size > 64)
            return ST_SHORT;
        if (frame_buf[size - 2] != CH_CR)
            return ST_NO_CR;
        if (((size - 3) % 2) != 0)
            return ST_ODD;
        for (int i = 1; i < size - 2; i++)
            if (nibble_of(frame_buf[i]) < 0)
                return ST_NON_HEX;
        n = (size - 3) / 2;
        for (int i = 0; i < n; i++)
        begin
            msg[i] = 8'(nibble_of(frame_buf[1 + 2 * i]) * 16 + nibble_of(frame_buf[2 + 2 * i]));
            sum += msg[i];
        end
        if ((sum & 255) != 0)
            return ST_LRC;
        if (msg[0] != my_slave)
            return ST_OK;
        fc = msg[1];
        answer[0] = msg[0];
        if (fc == FC_READ_INPUT)
        begin
            if (n - 1 < 6)
                return ST_SHORT;
            start_reg = {msg[2], msg[3]};
            qty = {msg[4], msg[5]};
            if (qty < 16'd1 || qty > QTY_MAX)
            begin
                answer[1] = EXC_FLAG | fc;
                answer[2] = EXC_VALUE;
                answer_len = 3;
            end
            else if (start_reg != my_register || qty != 16'd1)
            begin
                answer[1] = EXC_FLAG | fc;
                answer[2] = EXC_ADDR;
                answer_len = 3;
            end
            else
            begin
                answer[1] = FC_READ_INPUT;
                answer[2] = 8'd2;
                answer[3] = sensor[15:8];
                answer[4] = sensor[7:0];
                answer_len = 5;
            end
        end
        else
        begin
            answer[1] = EXC_FLAG | fc;
            answer[2] = EXC_FUNC;
            answer_len = 3;
        end
        return ST_OK;
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic [15:0] sensor);
        status_t    st;
        logic [7:0] sum;
        st = ST_OK;
        answer_len = 0;
        if (c == CH_COLON)
        begin
            if (buffered > 0)
            begin
                count_error();
                st = ST_RESTART;
            end
            frame_buf[0] = c;
            buffered = 1;
        end
        else if (buffered == 0)
        begin
            count_error();
            st = ST_STRAY;
        end
        else if (buffered >= 64)
        begin
            count_error();
            st = ST_OVERFLOW;
        end
        else
        begin
            frame_buf[buffered] = c;
            buffered++;
            if (c == CH_LF)
            begin
                st = judge_frame(sensor);
                if (st != ST_OK)
                    count_error();
                buffered = 0;
            end
        end
        if (answer_len == 0)
        begin
            pending_beats.push_back('{1'b0, 8'd0, 1'b1, st, errors_seen});
            return;
        end
        sum = 8'd0;
        pending_beats.push_back('{1'b1, CH_COLON, 1'b0, ST_OK, errors_seen});
        for (int i = 0; i < answer_len; i++)
        begin
            pending_beats.push_back('{1'b1, to_hex(answer[i][7:4]), 1'b0, ST_OK, errors_seen});
            pending_beats.push_back('{1'b1, to_hex(answer[i][3:0]), 1'b0, ST_OK, errors_seen});
            sum = sum + answer[i];
        end
        sum = 8'd0 - sum;
        pending_beats.push_back('{1'b1, to_hex(sum[7:4]), 1'b0, ST_OK, errors_seen});
        pending_beats.push_back('{1'b1, to_hex(sum[3:0]), 1'b0, ST_OK, errors_seen});
        pending_beats.push_back('{1'b1, CH_CR, 1'b0, ST_OK, errors_seen});
        pending_beats.push_back('{1'b1, CH_LF, 1'b1, ST_OK, errors_seen});
    endfunction

    // predict on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            predict_char(rx_char, sensor_value);
    end

    always @(posedge clk)
    begin
        beat_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat tx_char=%h status=%0d", $time, tx_char,
                         frame_status);
                failed = 1'b1;
            end
            else
            begin
                exp_b = pending_beats.pop_front();
                if (char_valid !== exp_b.is_char || tx_char !== exp_b.ch || last !== exp_b.fin
                    || frame_status !== exp_b.st || error_count !== exp_b.errs)
                begin
                    $display("%0t: expected cv=%b ch=%h last=%b st=%0d errs=%0d", $time,
                             exp_b.is_char, exp_b.ch, exp_b.fin, exp_b.st, exp_b.errs);
                    $display("%0t: actual   cv=%b ch=%h last=%b st=%0d errs=%0d", $time,
                             char_valid, tx_char, last, frame_status, error_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver back-pressure: random hold before each beat
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_char <= c;
        sensor_value <= 16'($urandom);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        random_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_frame(input byte_q_t msg, input bit bad_lrc, input bit corrupt);
        byte_q_t    line;
        logic [7:0] sum;
        int         pos;
        sum = 8'd0;
        line.push_back(CH_COLON);
        foreach (msg[i])
        begin
            line.push_back(to_hex(msg[i][7:4]));
            line.push_back(to_hex(msg[i][3:0]));
            sum = sum + msg[i];
        end
        sum = 8'd0 - sum + (bad_lrc ? 8'($urandom_range(1, 255)) : 8'd0);
        line.push_back(to_hex(sum[7:4]));
        line.push_back(to_hex(sum[3:0]));
        line.push_back(CH_CR);
        line.push_back(CH_LF);
        if (corrupt)
        begin
            pos = $urandom_range(1, line.size() - 1);
            line[pos] = 8'($urandom);
        end
        foreach (line[i])
            send_char(line[i]);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_SLAVE)
            my_slave = value[7:0];
        else
            my_register = value;
    endtask

    task automatic send_read(input logic [7:0] addr, input logic [7:0] fc,
                             input logic [15:0] start_reg, input logic [15:0] qty);
        send_frame('{addr, fc, start_reg[15:8], start_reg[7:0], qty[15:8], qty[7:0]},
                   1'b0, 1'b0);
    endtask

    task automatic test_answers();
        send_read(my_slave, FC_READ_INPUT, my_register, 16'd1);
        send_read(my_slave, FC_READ_INPUT, my_register, 16'd0);
        send_read(my_slave, FC_READ_INPUT, my_register, 16'h007E);
        send_read(my_slave, FC_READ_INPUT, my_register, QTY_MAX);
        send_read(my_slave, FC_READ_INPUT, my_register + 16'd1, 16'd1);
        send_read(my_slave, 8'h03, my_register, 16'd1);
        send_read(my_slave + 8'd1, FC_READ_INPUT, my_register, 16'd1);
    endtask

    task automatic test_frame_errors();
        send_char(8'h00);
        send_char(8'hFF);
        send_frame('{my_slave, FC_READ_INPUT}, 1'b0, 1'b0);
        send_frame('{my_slave, FC_READ_INPUT, 8'h00, 8'h01}, 1'b0, 1'b0);
        send_text(":0104\n");
        send_text(":0104000000010A\n");
        send_text(":01040000000\r\n");
        send_text(":0104000000010a\r\n");
        send_frame('{my_slave, FC_READ_INPUT, 8'h00, 8'h01, 8'h00, 8'h01}, 1'b1, 1'b0);
        send_char(CH_COLON);
        send_char("0");
        send_char(CH_COLON);
        for (int i = 0; i < 66; i++)
            send_char("A");
        send_char(CH_LF);
        send_char(CH_COLON);
        send_char(CH_CR);
        send_char(CH_LF);
    endtask

    task automatic test_config();
        write_reg(REG_SLAVE, 16'd247);
        write_reg(REG_START, 16'hFFFF);
        send_read(my_slave, FC_READ_INPUT, my_register, 16'd1);
        write_reg(REG_SLAVE, 16'd1);
        write_reg(REG_START, 16'd0);
    endtask

    task automatic test_random();
        byte_q_t     msg;
        logic [7:0]  addr;
        logic [15:0] start_reg;
        logic [15:0] qty;
        int          kind;
        while (random_chars < 320)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                quiet = ~quiet;
            if (kind == 1)
                write_reg(REG_SLAVE, 16'($urandom_range(1, 247)));
            else if (kind == 2)
                write_reg(REG_START, 16'($urandom));
            else if (kind < 5)
                send_char(8'($urandom));
            else
            begin
                addr = ($urandom_range(0, 5) == 0) ? 8'($urandom) : my_slave;
                start_reg = ($urandom_range(0, 2) == 0) ? 16'($urandom) : my_register;
                case ($urandom_range(0, 3))
                    0: qty = 16'($urandom);
                    1: qty = 16'($urandom_range(0, 128));
                    default: qty = 16'd1;
                endcase
                msg = '{addr, ($urandom_range(0, 4) == 0) ? 8'($urandom) : FC_READ_INPUT,
                        start_reg[15:8], start_reg[7:0], qty[15:8], qty[7:0]};
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0)
                    msg.push_back(8'($urandom));
                if ($urandom_range(0, 7) == 0)
                    msg = msg[0:$urandom_range(0, 5)];
                send_frame(msg, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_answers();
        test_frame_errors();
        test_config();
        test_random();
        wait_drained();
        if (!failed && pending_beats.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
